// ===== rtl/plt_lookup_pkg.sv =====
// types and constants of the piecewise linear time lookup
// used by the channel interfaces and the top level
package plt_lookup_pkg;

  typedef enum logic [1:0] {
    CfgPointCount = 2'd0,
    CfgScaleFactor = 2'd1,
    CfgHoldLast = 2'd2,
    CfgUnused = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    CmdLoad = 1'b0,
    CmdEval = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    StIdle,
    StDur,
    StLoc,
    StChk,
    StT2,
    StWalk,
    StFwd,
    StBwd,
    StIMul,
    StDivInit,
    StDiv,
    StIFin,
    StPkMul,
    StPkRnd,
    StFaMul,
    StDone
  } state_e;

  typedef struct packed {
    logic               command;
    logic [9:0]         point_index;
    logic signed [31:0] point_time;
    logic signed [31:0] point_value;
    logic signed [31:0] query_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] factor;
    logic signed [31:0] duration;
    logic signed [31:0] peak_factor;
    logic               saturated;
  } out_item_t;

  localparam logic signed [31:0] ScaleReset = 32'sh0100_0000;

endpackage

// ===== rtl/plt_if.sv =====
// valid/ready channel interfaces for request and result items
// depends on plt_lookup_pkg
interface plt_in_if import plt_lookup_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface plt_out_if import plt_lookup_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/piecewise_linear_time_lookup.sv =====
// piecewise linear time lookup, top level with sequencer and shared datapath
// depends on plt_lookup_pkg and the channel interfaces in plt_if.sv
//
// A load request writes one (time, value) point; the block is ready again in the
// next cycle. An evaluate request runs a small sequencer over one read port of
// the time and value memories and a single shared 33x33 multiplier: it reads the
// duration and current interval, walks the cursor one interval at a time, then
// for an interpolation multiplies, runs the bit-serial divider (a setup step
// and one quotient bit per cycle for 33 bits) and applies the sign, and finally
// does the two scaling multiplies with rounding and hands the result over. An
// empty table skips straight to the hand-over. The result sits in an output
// register, so the next request is taken while a result still waits; the
// sequencer holds its last step until that result has left.
module piecewise_linear_time_lookup import plt_lookup_pkg::*; #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  plt_in_if.sink      in_if,
  plt_out_if.source   out_if
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NW = $clog2(TABLE_DEPTH + 1);

  // memories, registered read
  logic signed [31:0] time_mem [TABLE_DEPTH];
  logic signed [31:0] value_mem [TABLE_DEPTH];
  logic [AW-1:0]      rd_addr;
  logic signed [31:0] rd_t, rd_v;

  // configuration
  logic [10:0]        point_count_q;
  logic signed [31:0] scale_q;
  logic               hold_last_q;

  // control
  state_e             state_q, state_d;
  logic [AW-1:0]      cursor_q, loc_q, loc_clamp;
  logic [NW-1:0]      n_eff;
  logic [31:0]        peak_q;
  logic [5:0]         cnt_q;

  // working registers
  logic signed [31:0] tq_q, t1_q, t2_q, v1_q, v2_q, last_v_q, dur_q;
  logic signed [32:0] val_q;
  logic [31:0]        span_q, dt_q, mag_q, rem_q;
  logic [32:0]        low_q;
  logic               dvneg_q;
  logic signed [65:0] mprod_q;
  logic signed [31:0] pk_res_q;
  logic               sat_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic in_acc, load_ok, out_free;

  assign in_acc   = in_if.valid && in_if.ready;
  assign load_ok  = 32'(in_if.payload.point_index) < TABLE_DEPTH;
  assign out_free = !out_valid_q || out_if.ready;
  assign in_if.ready = (state_q == StIdle);
  assign out_if.valid = out_valid_q;
  assign out_if.payload = out_q;

  // usable point count, capped at the depth
  always_comb begin
    if (32'(point_count_q) > TABLE_DEPTH) begin
      n_eff = NW'(TABLE_DEPTH);
    end else begin
      n_eff = NW'(point_count_q);
    end
    if (32'(cursor_q) >= 32'(n_eff)) begin
      loc_clamp = AW'(32'(n_eff) - 1);
    end else begin
      loc_clamp = cursor_q;
    end
  end

  // shared multiplier operands
  logic signed [32:0] mul_a, mul_b;
  always_comb begin
    case (state_q)
      StIMul: begin
        mul_a = $signed({1'b0, mag_q});
        mul_b = $signed({1'b0, dt_q});
      end
      StPkMul: begin
        mul_a = $signed({1'b0, peak_q});
        mul_b = {scale_q[31], scale_q};
      end
      default: begin
        mul_a = val_q;
        mul_b = {scale_q[31], scale_q};
      end
    endcase
  end

  // round half up at bit 24 and saturate to 32 bits
  logic signed [65:0] rnd_sum;
  logic [41:0]        rnd_sh;
  logic               rnd_hi, rnd_lo;
  logic signed [31:0] rnd_val;
  always_comb begin
    rnd_sum = mprod_q + 66'sd8388608;
    rnd_sh  = rnd_sum[65:24];
    rnd_hi  = !rnd_sh[41] && (|rnd_sh[40:31]);
    rnd_lo  = rnd_sh[41] && !(&rnd_sh[40:31]);
    if (rnd_hi) begin
      rnd_val = 32'sh7fff_ffff;
    end else if (rnd_lo) begin
      rnd_val = 32'sh8000_0000;
    end else begin
      rnd_val = $signed(rnd_sh[31:0]);
    end
  end

  // interval arithmetic for the interpolation setup
  logic signed [32:0] span_w, dt_w, dv_w;
  logic [31:0]        dt_clip;
  always_comb begin
    span_w = {t2_q[31], t2_q} - {t1_q[31], t1_q};
    dt_w   = {tq_q[31], tq_q} - {t1_q[31], t1_q};
    dv_w   = {v2_q[31], v2_q} - {v1_q[31], v1_q};
    if (tq_q <= t1_q) begin
      dt_clip = '0;
    end else if (dt_w[31:0] > span_w[31:0]) begin
      dt_clip = span_w[31:0];
    end else begin
      dt_clip = dt_w[31:0];
    end
  end

  // divider step: one quotient bit per cycle
  logic [32:0] div_trial;
  logic        div_ge;
  logic [64:0] num_w;
  assign div_trial = {rem_q, low_q[32]};
  assign div_ge    = div_trial >= {1'b0, span_q};
  assign num_w     = {1'b0, mprod_q[63:0]} + {34'd0, span_q[31:1]};

  logic fwd_ok, bwd_ok;
  assign fwd_ok = (32'(loc_q) + 2) < 32'(n_eff);
  assign bwd_ok = (loc_q != '0);

  // sequencer: next state and read address
  always_comb begin
    state_d = state_q;
    rd_addr = loc_q;
    case (state_q)
      StIdle: begin
        if (in_acc && in_if.payload.command == CmdEval) begin
          state_d = (n_eff == '0) ? StDone : StDur;
        end
      end
      StDur: begin
        rd_addr = AW'(32'(n_eff) - 1);
        state_d = StLoc;
      end
      StLoc: begin
        rd_addr = loc_clamp;
        state_d = StChk;
      end
      StChk: begin
        rd_addr = AW'(32'(loc_q) + 1);
        if ((tq_q < rd_t && loc_q == '0) || tq_q == rd_t ||
            (tq_q > rd_t && 32'(loc_q) == 32'(n_eff) - 1)) begin
          state_d = StPkMul;
        end else begin
          state_d = StT2;
        end
      end
      StT2: state_d = StWalk;
      StWalk: begin
        if (tq_q > t2_q) begin
          rd_addr = AW'(32'(loc_q) + 2);
          state_d = fwd_ok ? StFwd : StPkMul;
        end else if (tq_q < t1_q) begin
          rd_addr = AW'(32'(loc_q) - 1);
          state_d = bwd_ok ? StBwd : StPkMul;
        end else if (t2_q <= t1_q) begin
          state_d = StPkMul;
        end else begin
          state_d = StIMul;
        end
      end
      StFwd: state_d = StWalk;
      StBwd: state_d = StWalk;
      StIMul: state_d = StDivInit;
      StDivInit: state_d = StDiv;
      StDiv: begin
        if (cnt_q == 6'd32) begin
          state_d = StIFin;
        end
      end
      StIFin: state_d = StPkMul;
      StPkMul: state_d = StPkRnd;
      StPkRnd: state_d = StFaMul;
      // wait here until the previous result has left the output register
      StFaMul: begin
        if (out_free) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (in_acc && in_if.payload.command == CmdLoad && load_ok) begin
      time_mem[AW'(in_if.payload.point_index)]  <= in_if.payload.point_time;
      value_mem[AW'(in_if.payload.point_index)] <= in_if.payload.point_value;
    end
    rd_t <= time_mem[rd_addr];
    rd_v <= value_mem[rd_addr];
  end

  // control registers
  logic [31:0] load_mag, peak_base;
  always_comb begin
    load_mag  = in_if.payload.point_value[31] ? 32'(-in_if.payload.point_value)
                                              : 32'(in_if.payload.point_value);
    peak_base = (in_if.payload.point_index == '0) ? '0 : peak_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      point_count_q <= '0;
      scale_q       <= ScaleReset;
      hold_last_q   <= 1'b0;
      cursor_q      <= '0;
      peak_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgPointCount:  point_count_q <= cfg_data_i[10:0];
          CfgScaleFactor: scale_q       <= $signed(cfg_data_i);
          CfgHoldLast:    hold_last_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_acc && in_if.payload.command == CmdLoad && load_ok) begin
        peak_q <= (load_mag > peak_base) ? load_mag : peak_base;
      end
      if (state_q == StPkMul) begin
        cursor_q <= loc_q;
      end
      if (state_q == StDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    mprod_q <= mul_a * mul_b;
    case (state_q)
      StIdle: begin
        tq_q     <= in_if.payload.query_time;
        dur_q    <= '0;
        pk_res_q <= '0;
        val_q    <= '0;
        sat_q    <= 1'b0;
      end
      StLoc: begin
        dur_q    <= rd_t;
        last_v_q <= rd_v;
        loc_q    <= loc_clamp;
      end
      StChk: begin
        t1_q <= rd_t;
        v1_q <= rd_v;
        if (tq_q < rd_t && loc_q == '0) begin
          val_q <= '0;
        end else if (tq_q == rd_t) begin
          val_q <= {rd_v[31], rd_v};
        end else begin
          val_q <= hold_last_q ? {last_v_q[31], last_v_q} : '0;
        end
      end
      StT2, StFwd: begin
        t2_q <= rd_t;
        v2_q <= rd_v;
      end
      StBwd: begin
        t1_q <= rd_t;
        v1_q <= rd_v;
      end
      StWalk: begin
        if (tq_q > t2_q) begin
          if (fwd_ok) begin
            loc_q <= AW'(32'(loc_q) + 1);
            t1_q  <= t2_q;
            v1_q  <= v2_q;
          end else begin
            val_q <= hold_last_q ? {last_v_q[31], last_v_q} : '0;
          end
        end else if (tq_q < t1_q) begin
          if (bwd_ok) begin
            loc_q <= AW'(32'(loc_q) - 1);
            t2_q  <= t1_q;
            v2_q  <= v1_q;
          end else begin
            val_q <= '0;
          end
        end else begin
          val_q   <= {v1_q[31], v1_q};
          span_q  <= span_w[31:0];
          dt_q    <= dt_clip;
          dvneg_q <= dv_w[32];
          mag_q   <= dv_w[32] ? 32'(-dv_w) : dv_w[31:0];
        end
      end
      StDivInit: begin
        rem_q <= num_w[64:33];
        low_q <= num_w[32:0];
        cnt_q <= '0;
      end
      StDiv: begin
        rem_q <= div_ge ? 32'(div_trial - {1'b0, span_q}) : div_trial[31:0];
        low_q <= {low_q[31:0], div_ge};
        cnt_q <= cnt_q + 6'd1;
      end
      StIFin: begin
        val_q <= dvneg_q ? ({v1_q[31], v1_q} - $signed({1'b0, low_q[31:0]}))
                         : ({v1_q[31], v1_q} + $signed({1'b0, low_q[31:0]}));
      end
      StPkRnd: begin
        pk_res_q <= rnd_val;
        sat_q    <= rnd_hi || rnd_lo;
      end
      StFaMul: begin
        if (out_free) begin
          out_q.factor      <= rnd_val;
          out_q.duration    <= dur_q;
          out_q.peak_factor <= pk_res_q;
          out_q.saturated   <= sat_q || rnd_hi || rnd_lo;
        end
      end
      StDone: begin
        if (n_eff == '0 && out_free) begin
          out_q <= '0;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/plt_lookup_checker.sv =====
// port level checks for the piecewise linear time lookup
// depends on the top level's ports, attached by the bind below
module plt_lookup_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_cmd_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [96:0] out_data_i
);

  // an evaluate request keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_cmd_i |=> !in_ready_i)
    else $error("ready after evaluate request");

  // a new result only follows a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result without work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result changed while stalled");

endmodule

bind piecewise_linear_time_lookup plt_lookup_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .in_cmd_i    (in_if.payload.command),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_data_i  (out_if.payload)
);

// ===== dv/tb_piecewise_linear_time_lookup.sv =====
// self-checking testbench of the piecewise linear time lookup
// depends on plt_lookup_pkg, plt_if.sv and the block's top level
module tb_piecewise_linear_time_lookup;
  import plt_lookup_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = 1024;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  plt_in_if  in_if ();
  plt_out_if out_if ();

  piecewise_linear_time_lookup #(.TABLE_DEPTH(Depth)) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_if     (in_if),
    .out_if    (out_if)
  );

  // predictor state, mirrors the block's tables and registers
  logic signed [31:0] time_mem [Depth];
  logic signed [31:0] value_mem [Depth];
  int unsigned        cursor;
  logic [31:0]        peak_mag;
  int unsigned        num_points;
  logic signed [31:0] scale;
  bit                 hold_end;

  out_item_t expected_q[$];
  int        error_count;

  // idling controls
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  recv_hold;
  int  recv_hold_cycles;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  // q16.16 (or magnitude) times q8.24, round, floor shift, saturate
  function automatic logic signed [31:0] scale_q(input longint v, inout bit clip);
    longint p;
    longint r;
    p = v * longint'(scale) + (64'sd1 <<< 23);
    r = p >>> 24;
    if (r > 64'sd2147483647) begin
      clip = 1'b1;
      return 32'sh7fff_ffff;
    end
    if (r < -64'sd2147483648) begin
      clip = 1'b1;
      return 32'sh8000_0000;
    end
    return r[31:0];
  endfunction

  // linear interpolation on the interval starting at loc
  function automatic longint interp_at(input int unsigned loc, input longint t);
    longint t1, t2, v1, v2, dv;
    longint unsigned span, dt, mag, q;
    t1 = time_mem[loc];
    t2 = time_mem[loc+1];
    v1 = value_mem[loc];
    v2 = value_mem[loc+1];
    dv = v2 - v1;
    if (t2 <= t1) return v1;
    span = t2 - t1;
    dt = (t > t1) ? longint'(t - t1) : 0;
    if (dt > span) dt = span;
    mag = (dv < 0) ? -dv : dv;
    q = (mag * dt + span / 2) / span;
    return (dv < 0) ? v1 - longint'(q) : v1 + longint'(q);
  endfunction

  function automatic void predict_config(input cfg_idx_e idx, input logic [31:0] data);
    case (idx)
      CfgPointCount:  num_points = data[10:0];
      CfgScaleFactor: scale = data;
      CfgHoldLast:    hold_end = data[0];
      default: ;
    endcase
  endfunction

  // applies one request; a result is pushed for each evaluate
  function automatic void predict_request(input in_item_t req);
    out_item_t   res;
    bit          clip;
    int unsigned n, loc;
    longint      t, t1, t2;
    logic [31:0] m;
    bit          done;
    if (req.command == CmdLoad) begin
      time_mem[req.point_index] = req.point_time;
      value_mem[req.point_index] = req.point_value;
      m = req.point_value[31] ? -req.point_value : req.point_value;
      if (req.point_index == 0) peak_mag = '0;
      if (m > peak_mag) peak_mag = m;
      return;
    end
    res = '0;
    clip = 1'b0;
    n = (num_points > Depth) ? Depth : num_points;
    if (n != 0) begin
      res.duration = time_mem[n-1];
      res.peak_factor = scale_q(longint'({32'd0, peak_mag}), clip);
      t = req.query_time;
      loc = (cursor >= n) ? n - 1 : cursor;
      t1 = time_mem[loc];
      if (t < t1 && loc == 0) begin
        res.factor = '0;
      end else if (t == t1) begin
        res.factor = scale_q(value_mem[loc], clip);
      end else if (t > t1 && loc == n - 1) begin
        if (hold_end) res.factor = scale_q(value_mem[n-1], clip);
      end else begin
        done = 1'b0;
        t2 = time_mem[loc+1];
        if (t > t2) begin
          while (t > t2 && loc + 2 < n) begin
            loc++;
            t1 = t2;
            t2 = time_mem[loc+1];
          end
          if (t > t2) begin
            done = 1'b1;
            if (hold_end) res.factor = scale_q(value_mem[n-1], clip);
          end
        end else if (t < t1) begin
          while (t < t1 && loc > 0) begin
            loc--;
            t1 = time_mem[loc];
          end
          if (t < t1) done = 1'b1;
        end
        if (!done) res.factor = scale_q(interp_at(loc, t), clip);
      end
      cursor = loc;
    end
    res.saturated = clip;
    expected_q.push_back(res);
  endfunction

  // ---------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------

  // offers one request, with random idle cycles ahead of it
  task automatic send_request(input in_item_t req);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.payload <= req;
    do @(posedge clk_i); while (!in_if.ready);
    predict_request(req);
  endtask

  task automatic load_point(input int idx, input int signed tm, input int signed val);
    in_item_t req;
    req = '0;
    req.command = CmdLoad;
    req.point_index = 10'(idx);
    req.point_time = tm;
    req.point_value = val;
    send_request(req);
  endtask

  task automatic evaluate_at(input int signed tq);
    in_item_t req;
    req = '0;
    req.point_index = 10'($urandom());
    req.point_time = $urandom();
    req.point_value = $urandom();
    req.command = CmdEval;
    req.query_time = tq;
    send_request(req);
  endtask

  // waits for every result and then for the block to fall idle
  task automatic drain();
    int guard;
    guard = 0;
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] data);
    in_if.valid <= 1'b0;
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    predict_config(idx, data);
    cfg_we_i <= 1'b0;
  endtask

  // a non-decreasing table of count points, small steps with equal times
  task automatic build_table(input int count);
    int signed tm;
    int signed step;
    tm = $urandom_range(1, 0) ? -$urandom_range(400000) : $urandom_range(400000);
    for (int i = 0; i < count; i++) begin
      load_point(i, tm, $urandom());
      step = ($urandom_range(4) == 0) ? 0 : $urandom_range(300000, 1);
      tm = tm + step;
    end
  endtask

  // a query near the loaded times, mostly inside the path
  function automatic int signed pick_query(input int count);
    int idx;
    case ($urandom_range(9))
      0: return $urandom();
      1: return time_mem[0] - $urandom_range(5000);
      2: return time_mem[count-1] + $urandom_range(5000);
      3: return time_mem[$urandom_range(count - 1)];
      default: begin
        idx = $urandom_range(count - 1);
        return time_mem[idx] + $urandom_range(300000);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (recv_hold) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // long hold-off counted here, so the block fills and stalls its input
  always @(posedge clk_i) begin
    if (recv_hold_cycles > 0) begin
      recv_hold <= 1'b1;
      recv_hold_cycles <= recv_hold_cycles - 1;
    end else begin
      recv_hold <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    out_item_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.payload;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, got);
        error_count++;
      end else begin
        want = expected_q.pop_front();
        if (got.factor !== want.factor) begin
          $display("%0t: factor expected %h actual %h", $time, want.factor, got.factor);
          error_count++;
        end
        if (got.duration !== want.duration) begin
          $display("%0t: duration expected %h actual %h", $time, want.duration,
                   got.duration);
          error_count++;
        end
        if (got.peak_factor !== want.peak_factor) begin
          $display("%0t: peak_factor expected %h actual %h", $time, want.peak_factor,
                   got.peak_factor);
          error_count++;
        end
        if (got.saturated !== want.saturated) begin
          $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                   got.saturated);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // empty table, then edge cases on a small hand-made path
  task automatic test_directed();
    evaluate_at(32'sh0001_0000);
    load_point(0, -32'sd65536, 32'sh7fff_ffff);
    load_point(1, 32'sd0, 32'sh8000_0000);
    load_point(2, 32'sd0, 32'sd65536);
    load_point(3, 32'sd131072, -32'sd65536);
    load_point(5, 32'sh7fff_ffff, 32'sd0);
    load_point(4, 32'sd196608, 32'sd1);
    drain();
    write_reg(CfgPointCount, 32'd4);
    evaluate_at(32'sh8000_0000);  // before the first point
    evaluate_at(-32'sd65536);     // on the first point
    evaluate_at(-32'sd32768);     // inside, falling full range
    evaluate_at(32'sd0);          // zero-width interval
    evaluate_at(32'sd65537);
    evaluate_at(32'sh7fff_ffff);  // past the end, zero
    drain();
    write_reg(CfgHoldLast, 32'd1);
    write_reg(CfgScaleFactor, 32'h7fff_ffff);
    evaluate_at(32'sh7fff_ffff);  // held and clipped
    evaluate_at(-32'sd100);       // walk back
    drain();
    write_reg(CfgScaleFactor, 32'h8000_0000);
    evaluate_at(32'sd65536);
    drain();
    write_reg(CfgPointCount, 32'd1);  // cursor beyond count is clamped
    drain();
    write_reg(CfgPointCount, 32'd1);
    evaluate_at(32'sd5);
    drain();
    write_reg(CfgPointCount, 32'd6);
    evaluate_at(32'sh7fff_fff0);
    drain();
    write_reg(CfgScaleFactor, 32'h0100_0000);
    load_point(Depth - 1, 32'sd0, 32'sd3);  // top index loads, peak still counts
    evaluate_at(32'sd0);
    drain();
  endtask

  // random paths and queries over a setting of the registers
  task automatic test_random(input int count, input int items, input logic [31:0] scl,
                             input bit hold);
    int n;
    write_reg(CfgPointCount, count);
    write_reg(CfgScaleFactor, scl);
    write_reg(CfgHoldLast, hold);
    build_table(count);
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(19) == 0) begin
        // reload of a point, times kept non-decreasing
        n = $urandom_range(count - 1);
        load_point(n, time_mem[n], $urandom());
      end else begin
        evaluate_at(pick_query(count));
      end
    end
  endtask

  // point_count at the top and above depth, only a few queries
  task automatic test_count_limit();
    write_reg(CfgPointCount, 32'h7ff);
    evaluate_at(32'sd0);
    drain();
    write_reg(CfgPointCount, Depth);
    evaluate_at(time_mem[Depth-1]);
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgPointCount;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.payload = '0;
    recv_hold = 1'b0;
    recv_hold_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    error_count = 0;
    cursor = 0;
    peak_mag = '0;
    num_points = 0;
    scale = ScaleReset;
    hold_end = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();

    // the top entry is loaded by the directed part, the cursor sits low
    test_count_limit();

    test_random(8, 120, 32'h0100_0000, 1'b0);
    drain();
    send_idle_pct = 58;
    test_random(2, 90, 32'hff00_0000, 1'b1);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 58;
    test_random(30, 90, $urandom(), 1'b0);
    drain();
    send_idle_pct = 10;
    recv_stall_pct = 10;
    // receiver holds off while requests keep coming
    recv_hold_cycles = 600;
    test_random(16, 100, 32'h7fff_ffff, 1'b1);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(5, 60, 32'h8000_0000, 1'b0);
    drain();

    if (error_count == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
